// ===== src/wess_pkg.sv =====
// ----------------------------------------------------------------------------
// wess_pkg
// Shared constants, codes, control structs and the falloff table of the
// water entry splash stamp.
// ----------------------------------------------------------------------------
package wess_pkg;

  // grid geometry, grid size must be a power of two
  localparam int GRID_SIZE  = 64;
  localparam int GRID_BITS  = $clog2(GRID_SIZE);
  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
  localparam int CELL_BITS  = $clog2(CELL_COUNT);

  // bodies and stamp radius
  localparam int MAX_BODIES = 256;
  localparam int FLAG_BITS  = $clog2(MAX_BODIES);
  localparam int MAX_RADIUS = 4;
  localparam int RI_BITS    = $clog2(MAX_RADIUS);
  localparam int OFS_BITS   = $clog2(MAX_RADIUS) + 2;
  localparam int D2_DEPTH   = 2 * MAX_RADIUS * MAX_RADIUS + 1;
  localparam int D2_BITS    = $clog2(D2_DEPTH);

  // arithmetic constants
  localparam logic [31:0] SPEED_MIN = 32'd6554;
  localparam logic [16:0] FOAM_ONE  = 17'h10000;
  localparam logic [31:0] DISP_MAX  = 32'h7fff_ffff;

  // command modes
  localparam logic [1:0] MODE_BODY  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CPM      = 2'd0;
  localparam logic [1:0] CFG_STRENGTH = 2'd1;
  localparam logic [1:0] CFG_RADIUS   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       flag_upd;
    logic [1:0] sq_sel;
    logic       sq_acc;
    logic       sqrt_start;
    logic       coord;
    logic       stamp_init;
    logic       cell_rd;
    logic       mul_lo;
    logic       mul_hi;
    logic       cell_wr;
    logic       cell_next;
    logic       load_cell;
    logic       read_cell;
    logic       read_capture;
  } wess_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       entry;
    logic       sqrt_busy;
    logic       fast;
    logic       in_disk;
    logic       last;
  } wess_stat_t;

  typedef logic [MAX_RADIUS-1:0][D2_DEPTH-1:0][16:0] fall_tab_t;

  // falloff 1 - floor(sqrt(d2)*65536)/r in Q1.16, zero outside the disk
  function automatic logic [16:0] calc_fall(int d2, int r);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] q;
    v   = 64'(d2) << 32;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    case (r)
      1:       q = res;
      2:       q = res >> 1;
      3:       q = res / 3;
      4:       q = res >> 2;
      5:       q = res / 5;
      6:       q = res / 6;
      7:       q = res / 7;
      8:       q = res >> 3;
      default: q = res;
    endcase
    if (d2 > r * r) begin
      return 17'd0;
    end
    return 17'(64'h10000 - q);
  endfunction

  function automatic fall_tab_t build_fall();
    fall_tab_t t;
    t = '0;
    for (int r = 1; r <= MAX_RADIUS; r++) begin
      for (int d = 0; d < D2_DEPTH; d++) begin
        t[r-1][d] = calc_fall(d, r);
      end
    end
    return t;
  endfunction

  localparam fall_tab_t FALL_TAB = build_fall();

endpackage

// ===== src/wess_isqrt.sv =====
// ----------------------------------------------------------------------------
// wess_isqrt
// Iterative integer square root, one result bit per cycle over 32 steps.
// ----------------------------------------------------------------------------
module wess_isqrt
  import wess_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bt;
  logic [63:0] trial;

  assign trial = res + bt;
  assign root  = res[31:0];

  // control: run until the last bit pair is done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bt[0]) begin
      busy <= 1'b0;
    end
  end

  // one bit pair per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= radicand;
      res <= '0;
      bt  <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
      bt <= bt >> 2;
    end
  end

endmodule

// ===== src/wess_dpath.sv =====
// ----------------------------------------------------------------------------
// wess_dpath
// Datapath: configuration, submerged flags, speed, cell coordinates,
// disk scan and the displacement and foam grid memories.
// ----------------------------------------------------------------------------
module wess_dpath
  import wess_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wess_cmd_t          cmd,
  output wess_stat_t         stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [1:0]         mode,
  input  logic [7:0]         body_id,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] water_height,
  input  logic [11:0]        cell_index,
  input  logic signed [31:0] cell_displacement,
  input  logic [16:0]        cell_foam,
  output logic               entered,
  output logic               splashed,
  output logic [6:0]         cells_touched,
  output logic signed [31:0] read_displacement,
  output logic [16:0]        read_foam
);

  // configuration registers
  logic [23:0] cpm;
  logic [23:0] strength;
  logic [2:0]  radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpm      <= 24'd41943;
      strength <= 24'd32768;
      radius   <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CPM:      cpm      <= cfg_data;
        CFG_STRENGTH: strength <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[2:0];
        default:      ;
      endcase
    end
  end

  // latched command fields
  logic [1:0]         mode_q;
  logic [7:0]         id_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [31:0] vel_x_q, vel_y_q, vel_z_q;
  logic signed [31:0] water_q;
  logic [11:0]        cidx_q;
  logic signed [31:0] cdisp_q;
  logic [16:0]        cfoam_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      id_q    <= body_id;
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      pos_z_q <= pos_z;
      vel_x_q <= vel_x;
      vel_y_q <= vel_y;
      vel_z_q <= vel_z;
      water_q <= water_height;
      cidx_q  <= cell_index;
      cdisp_q <= cell_displacement;
      cfoam_q <= cell_foam;
    end
  end

  // submerged flags, cleared to dry at reset
  logic [MAX_BODIES-1:0] flags;
  logic                  id_ok;
  logic                  now_wet;
  logic                  entry;
  logic [FLAG_BITS-1:0]  fidx;

  assign id_ok   = {1'b0, id_q} < 9'(MAX_BODIES);
  assign fidx    = id_q[FLAG_BITS-1:0];
  assign now_wet = water_q > pos_y_q;
  assign entry   = id_ok && now_wet && !flags[fidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.flag_upd && id_ok) begin
      flags[fidx] <= now_wet;
    end
  end

  // sum of squared velocity components, one per cycle
  logic signed [31:0] vsel;
  logic [31:0]        vabs;
  logic [63:0]        vsq;
  logic [63:0]        sq_sum;

  always_comb begin
    case (cmd.sq_sel)
      2'd0:    vsel = vel_x_q;
      2'd1:    vsel = vel_y_q;
      default: vsel = vel_z_q;
    endcase
  end

  assign vabs = vsel[31] ? 32'(-vsel) : 32'(vsel);
  assign vsq  = vabs * vabs;

  always_ff @(posedge clk) begin
    if (cmd.sq_acc) begin
      sq_sum <= (cmd.sq_sel == 2'd0) ? vsq : sq_sum + vsq;
    end
  end

  // speed
  logic        sqrt_busy;
  logic [31:0] speed;

  wess_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sq_sum),
    .busy     (sqrt_busy),
    .root     (speed)
  );

  // cell coordinates and base amplitude products
  logic signed [56:0] prod_x;
  logic signed [56:0] prod_z;
  logic [55:0]        prod_b;

  always_ff @(posedge clk) begin
    if (cmd.coord) begin
      prod_x <= pos_x_q * $signed({1'b0, cpm});
      prod_z <= pos_z_q * $signed({1'b0, cpm});
      prod_b <= speed * strength;
    end
  end

  // clamped radius
  logic [OFS_BITS-1:0] rc;
  logic [RI_BITS-1:0]  ridx;

  always_comb begin
    if (radius == 3'd0) begin
      rc = OFS_BITS'(1);
    end else if (OFS_BITS'(radius) > OFS_BITS'(MAX_RADIUS)) begin
      rc = OFS_BITS'(MAX_RADIUS);
    end else begin
      rc = OFS_BITS'(radius);
    end
  end

  assign ridx = RI_BITS'(rc - 1'b1);

  // disk scan position
  logic [GRID_BITS-1:0]        cx, cz;
  logic [39:0]                 base;
  logic signed [OFS_BITS-1:0]  dx, dz;
  logic signed [2*OFS_BITS-1:0] dx2, dz2;
  logic [D2_BITS-1:0]          d2;
  logic [D2_BITS-1:0]          r2;
  logic [GRID_BITS-1:0]        xi, zi;
  logic [CELL_BITS-1:0]        scan_addr;

  assign dx2       = dx * dx;
  assign dz2       = dz * dz;
  assign d2        = D2_BITS'(dx2) + D2_BITS'(dz2);
  assign r2        = D2_BITS'(rc) * D2_BITS'(rc);
  assign xi        = cx + GRID_BITS'(dx);
  assign zi        = cz + GRID_BITS'(dz);
  assign scan_addr = {zi, xi};

  always_ff @(posedge clk) begin
    if (cmd.stamp_init) begin
      cx   <= prod_x[32+GRID_BITS-1:32] + GRID_BITS'(GRID_SIZE / 2);
      cz   <= prod_z[32+GRID_BITS-1:32] + GRID_BITS'(GRID_SIZE / 2);
      base <= prod_b[55:16];
      dx   <= -$signed(rc);
      dz   <= -$signed(rc);
    end else if (cmd.cell_next) begin
      if (dx == $signed(rc)) begin
        dx <= -$signed(rc);
        dz <= dz + 1'b1;
      end else begin
        dx <= dx + 1'b1;
      end
    end
  end

  // amplitude in two partial products
  logic [CELL_BITS-1:0] addr_r;
  logic [16:0]          fall_r;
  logic [36:0]          plo, phi;
  logic [56:0]          amp_full;
  logic [40:0]          amp;

  always_ff @(posedge clk) begin
    if (cmd.cell_rd) begin
      addr_r <= scan_addr;
      fall_r <= FALL_TAB[ridx][d2];
    end
    if (cmd.mul_lo) begin
      plo <= base[19:0] * fall_r;
    end
    if (cmd.mul_hi) begin
      phi <= base[39:20] * fall_r;
    end
  end

  assign amp_full = {phi, 20'd0} + 57'(plo);
  assign amp      = amp_full[56:16];

  // grid memories
  logic signed [31:0]  disp_mem [CELL_COUNT];
  logic [16:0]         foam_mem [CELL_COUNT];
  logic signed [31:0]  disp_rd;
  logic [16:0]         foam_rd;
  logic                cell_ok;
  logic                mem_we;
  logic                mem_re;
  logic [CELL_BITS-1:0] wa, ra;
  logic signed [31:0]  wd_disp;
  logic [16:0]         wd_foam;
  logic signed [43:0]  dsum;
  logic [39:0]         half;
  logic [16:0]         room;

  assign cell_ok = {1'b0, cidx_q} < 13'(CELL_COUNT);
  assign dsum    = 44'(disp_rd) + $signed({3'd0, amp});
  assign half    = amp[40:1];
  assign room    = FOAM_ONE - foam_rd;

  // write port and read port selection
  always_comb begin
    mem_we  = 1'b0;
    wa      = addr_r;
    wd_disp = disp_rd;
    wd_foam = foam_rd;
    if (cmd.load_cell) begin
      mem_we  = cell_ok;
      wa      = cidx_q[CELL_BITS-1:0];
      wd_disp = cdisp_q;
      wd_foam = (cfoam_q > FOAM_ONE) ? FOAM_ONE : cfoam_q;
    end else if (cmd.cell_wr) begin
      mem_we  = 1'b1;
      wd_disp = (dsum > $signed(44'(DISP_MAX))) ? $signed(DISP_MAX) : dsum[31:0];
      wd_foam = (half >= 40'(room)) ? FOAM_ONE : foam_rd + half[16:0];
    end
  end

  assign mem_re = cmd.cell_rd || cmd.read_cell;
  assign ra     = cmd.read_cell ? cidx_q[CELL_BITS-1:0] : scan_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      disp_mem[wa] <= wd_disp;
      foam_mem[wa] <= wd_foam;
    end
    if (mem_re) begin
      disp_rd <= disp_mem[ra];
      foam_rd <= foam_mem[ra];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entered           <= 1'b0;
      splashed          <= 1'b0;
      cells_touched     <= '0;
      read_displacement <= '0;
      read_foam         <= '0;
    end else begin
      if (cmd.flag_upd) begin
        entered <= entry;
      end
      if (cmd.stamp_init) begin
        splashed <= 1'b1;
      end
      if (cmd.cell_wr) begin
        cells_touched <= cells_touched + 1'b1;
      end
      if (cmd.read_capture && cell_ok) begin
        read_displacement <= disp_rd;
        read_foam         <= foam_rd;
      end
    end
  end

  // status
  assign stat.mode      = mode_q;
  assign stat.entry     = entry;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.fast      = speed >= SPEED_MIN;
  assign stat.in_disk   = d2 <= r2;
  assign stat.last      = (dx == $signed(rc)) && (dz == $signed(rc));

endmodule

// ===== src/wess_ctrl.sv =====
// ----------------------------------------------------------------------------
// wess_ctrl
// Controller: sequences body events, grid cell loads and reads.
// ----------------------------------------------------------------------------
module wess_ctrl
  import wess_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  wess_stat_t stat,
  output wess_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_FLAG  = 5'd2;
  localparam logic [4:0] S_SQ0   = 5'd3;
  localparam logic [4:0] S_SQ1   = 5'd4;
  localparam logic [4:0] S_SQ2   = 5'd5;
  localparam logic [4:0] S_SQRT  = 5'd6;
  localparam logic [4:0] S_WAIT  = 5'd7;
  localparam logic [4:0] S_CHECK = 5'd8;
  localparam logic [4:0] S_COORD = 5'd9;
  localparam logic [4:0] S_INIT  = 5'd10;
  localparam logic [4:0] S_SCAN  = 5'd11;
  localparam logic [4:0] S_MUL0  = 5'd12;
  localparam logic [4:0] S_MUL1  = 5'd13;
  localparam logic [4:0] S_WR    = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;
  localparam logic [4:0] S_WRITE = 5'd16;
  localparam logic [4:0] S_READ  = 5'd17;
  localparam logic [4:0] S_RDCAP = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.mode)
          MODE_BODY:  state_next = S_FLAG;
          MODE_WRITE: state_next = S_WRITE;
          MODE_READ:  state_next = S_READ;
          default:    state_next = S_DONE;
        endcase
      end
      S_FLAG: begin
        cmd.flag_upd = 1'b1;
        state_next   = stat.entry ? S_SQ0 : S_DONE;
      end
      S_SQ0: begin
        cmd.sq_acc = 1'b1;
        cmd.sq_sel = 2'd0;
        state_next = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq_acc = 1'b1;
        cmd.sq_sel = 2'd1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq_acc = 1'b1;
        cmd.sq_sel = 2'd2;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.sqrt_busy) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.fast ? S_COORD : S_DONE;
      end
      S_COORD: begin
        cmd.coord  = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.stamp_init = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (stat.in_disk) begin
          cmd.cell_rd = 1'b1;
          state_next  = S_MUL0;
        end else begin
          cmd.cell_next = 1'b1;
          state_next    = stat.last ? S_DONE : S_SCAN;
        end
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.cell_wr   = 1'b1;
        cmd.cell_next = 1'b1;
        state_next    = stat.last ? S_DONE : S_SCAN;
      end
      S_WRITE: begin
        cmd.load_cell = 1'b1;
        state_next    = S_DONE;
      end
      S_READ: begin
        cmd.read_cell = 1'b1;
        state_next    = S_RDCAP;
      end
      S_RDCAP: begin
        cmd.read_capture = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/water_entry_splash_stamp.sv =====
// ----------------------------------------------------------------------------
// water_entry_splash_stamp
// Toroidal displacement and foam grid with a splash stamp on body entry.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a clock edge with start high and busy low.
//   mode selects a body event, a grid cell load or a grid cell read; the
//   command fields are captured at that edge.
//   Exactly one result per command: done is high for one cycle and the
//   result ports hold entered, splashed, cells_touched, read_displacement
//   and read_foam in that cycle. The receiver cannot stall.
//   The time from transfer to done depends on the command: an entry
//   below the speed threshold waits for the 32-step square root, and
//   an entry with splash also scans the (2r+1)^2 positions around the
//   body, with r the clamped radius, and does one grid memory
//   read-modify-write for each cell in the disk.
//   One command at a time; busy stays high until done.
//   Configuration writes over cfg_we, cfg_index, cfg_data take effect at
//   once; the user must make them only while busy is low (unenforced).
//   Synchronous reset clears all bodies to dry and restores the register
//   defaults; grid cells are undefined until loaded.
// ----------------------------------------------------------------------------
module water_entry_splash_stamp
  import wess_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [1:0]         mode,
  input  logic [7:0]         body_id,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] water_height,
  input  logic [11:0]        cell_index,
  input  logic signed [31:0] cell_displacement,
  input  logic [16:0]        cell_foam,
  output logic               entered,
  output logic               splashed,
  output logic [6:0]         cells_touched,
  output logic signed [31:0] read_displacement,
  output logic [16:0]        read_foam
);

  wess_cmd_t  cmd;
  wess_stat_t stat;

  // sequencing
  wess_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic and storage
  wess_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .body_id           (body_id),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z),
    .vel_x             (vel_x),
    .vel_y             (vel_y),
    .vel_z             (vel_z),
    .water_height      (water_height),
    .cell_index        (cell_index),
    .cell_displacement (cell_displacement),
    .cell_foam         (cell_foam),
    .entered           (entered),
    .splashed          (splashed),
    .cells_touched     (cells_touched),
    .read_displacement (read_displacement),
    .read_foam         (read_foam)
  );

endmodule

// ===== src/wess_check.sv =====
// ----------------------------------------------------------------------------
// wess_check
// Port-level checks of the command handshake and result consistency.
// ----------------------------------------------------------------------------
module wess_check
  import wess_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       entered,
  input logic       splashed,
  input logic [6:0] cells_touched
);

  // a transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("no busy after command transfer");

  // a result only appears while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a splash needs an entry
  a_splash_entry: assert property (@(posedge clk) disable iff (rst)
    done && splashed |-> entered)
    else $error("splash without entry");

  // cells are only touched by a splash
  a_cells_splash: assert property (@(posedge clk) disable iff (rst)
    done && (cells_touched != 7'd0) |-> splashed)
    else $error("cells touched without splash");

endmodule

bind water_entry_splash_stamp wess_check u_wess_check (.*);
